FILE: design/rsh_pkg.sv
// ----------------------------------------------------------------------------
// rsh_pkg
// Shared constants and types for the ray-sphere hit distance pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rsh_pkg;

   // default coordinate width, signed fixed point
   localparam int RSH_COORD_WIDTH = 32;

   // multiplier digit handled by one product cell
   localparam int RSH_DIGIT = 8;

   typedef struct packed {
      logic hit;
      logic front_hit;
      logic invalid;
   } rsh_flags_type;

endpackage

`default_nettype wire

FILE: design/rsh_mul_cell.sv
// ----------------------------------------------------------------------------
// rsh_mul_cell
// One digit of a shift-add product chain: adds multiplicand times one
// multiplier digit into the running sum and hands everything on.
// ----------------------------------------------------------------------------
`default_nettype none

module rsh_mul_cell #(
   parameter int MW  = 66,
   parameter int DW  = 72,
   parameter int PW  = 132,
   parameter int XW  = 1,
   parameter int IDX = 0,
   parameter int DIG = 8
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          up_vld,
   input  wire logic [MW-1:0] up_mcand,
   input  wire logic [DW-1:0] up_mplier,
   input  wire logic [PW-1:0] up_acc,
   input  wire logic [XW-1:0] up_side,
   output logic               dn_vld,
   output logic      [MW-1:0] dn_mcand,
   output logic      [DW-1:0] dn_mplier,
   output logic      [PW-1:0] dn_acc,
   output logic      [XW-1:0] dn_side
);

   localparam int SH  = IDX * DIG;
   localparam int PPW = MW + DIG;

   logic [DIG-1:0] digit;
   logic [PPW-1:0] part;
   logic           vld_ff;
   logic [MW-1:0]  mcand_ff;
   logic [DW-1:0]  mplier_ff;
   logic [PW-1:0]  acc_ff, acc_in;
   logic [XW-1:0]  side_ff;

   assign digit  = up_mplier[SH +: DIG];
   assign part   = PPW'(up_mcand) * PPW'(digit);
   assign acc_in = up_acc + (PW'(part) << SH);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= up_vld;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff  <= up_mcand;
      mplier_ff <= up_mplier;
      acc_ff    <= acc_in;
      side_ff   <= up_side;
   end

   assign dn_vld    = vld_ff;
   assign dn_mcand  = mcand_ff;
   assign dn_mplier = mplier_ff;
   assign dn_acc    = acc_ff;
   assign dn_side   = side_ff;

endmodule

`default_nettype wire

FILE: design/rsh_search_cell.sv
// ----------------------------------------------------------------------------
// rsh_search_cell
// One bit of a restoring root search: sets root bit BIT when
// (root + 2^BIT)^2 * m still fits, keeping remainder and root*m up to date.
// ----------------------------------------------------------------------------
`default_nettype none

module rsh_search_cell #(
   parameter int RW  = 132,
   parameter int QW  = 66,
   parameter int QAW = 66,
   parameter int MW  = 1,
   parameter int XW  = 1,
   parameter int BIT = 0
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           up_vld,
   input  wire logic [RW-1:0]  up_rem,
   input  wire logic [QW-1:0]  up_root,
   input  wire logic [QAW-1:0] up_qa,
   input  wire logic [MW-1:0]  up_mul,
   input  wire logic [XW-1:0]  up_side,
   output logic                dn_vld,
   output logic      [RW-1:0]  dn_rem,
   output logic      [QW-1:0]  dn_root,
   output logic      [QAW-1:0] dn_qa,
   output logic      [MW-1:0]  dn_mul,
   output logic      [XW-1:0]  dn_side
);

   localparam int TW = RW + 2;

   logic [TW-1:0]  test;
   logic           take;
   logic           vld_ff;
   logic [RW-1:0]  rem_ff, rem_in;
   logic [QW-1:0]  root_ff, root_in;
   logic [QAW-1:0] qa_ff, qa_in;
   logic [MW-1:0]  mul_ff;
   logic [XW-1:0]  side_ff;

   // (q + 2^b)^2 m - q^2 m = q m 2^(b+1) + m 2^(2b)
   assign test    = (TW'(up_qa) << (BIT + 1)) + (TW'(up_mul) << (2 * BIT));
   assign take    = test <= TW'(up_rem);
   assign rem_in  = take ? up_rem - test[RW-1:0] : up_rem;
   assign root_in = up_root | (QW'(take) << BIT);
   assign qa_in   = take ? up_qa + (QAW'(up_mul) << BIT) : up_qa;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= up_vld;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      root_ff <= root_in;
      qa_ff   <= qa_in;
      mul_ff  <= up_mul;
      side_ff <= up_side;
   end

   assign dn_vld  = vld_ff;
   assign dn_rem  = rem_ff;
   assign dn_root = root_ff;
   assign dn_qa   = qa_ff;
   assign dn_mul  = mul_ff;
   assign dn_side = side_ff;

endmodule

`default_nettype wire

FILE: design/ray_sphere_hit_distance.sv
// ----------------------------------------------------------------------------
// ray_sphere_hit_distance
// Fully pipelined ray-sphere intersection distance, one pair per cycle.
//
//   channel  ports           handshake
//   -------  --------------  ------------------------------------------
//   request  start, req_*    taken at a clock edge with start high, busy low
//   result   rsp_*           rsp_strobe high for one cycle per transaction
//
// One transaction enters every cycle; busy is never raised and results
// cannot be held off, so nothing stalls. Each request passes the offset,
// product, dot-product and magnitude registers, the h*h and a*|k| product
// chains, the discriminant register, the root search, the root-choice
// register, the N*N chain, the quotient search and the result register,
// built from product cells and root-search cells, one root bit per cell.
// Synchronous reset clears only the valid bits of the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_sphere_hit_distance
   import rsh_pkg::*;
#(
   parameter int COORD_WIDTH = RSH_COORD_WIDTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic signed [COORD_WIDTH-1:0] req_ray_origin_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_ray_origin_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_ray_origin_z,
   input  wire logic signed [COORD_WIDTH-1:0] req_ray_dir_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_ray_dir_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_ray_dir_z,
   input  wire logic signed [COORD_WIDTH-1:0] req_center_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_center_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_center_z,
   input  wire logic        [COORD_WIDTH-2:0] req_sphere_radius,
   output logic                               rsp_strobe,
   output logic                               rsp_hit,
   output logic                               rsp_front_hit,
   output logic                               rsp_invalid,
   output logic signed      [COORD_WIDTH-1:0] rsp_distance
);

   localparam int W    = COORD_WIDTH;
   localparam int LW   = W + 1;
   localparam int PRW  = 2 * W + 1;
   localparam int LLW  = 2 * LW;
   localparam int HW   = 2 * W + 3;
   localparam int HM   = 2 * W + 2;
   localparam int AW   = 2 * W;
   localparam int CW   = 2 * W + 2;
   localparam int RADW = W - 1;
   localparam int KW   = 2 * W + 3;
   localparam int SQW  = 2 * HM;
   localparam int NW   = HM + 2;
   localparam int NMW  = HM + 1;
   localparam int NSQW = 2 * NMW;
   localparam int QW   = W - 1;
   localparam int QAW  = 3 * W - 1;
   localparam int DIG  = RSH_DIGIT;
   localparam int NC1  = (HM + DIG - 1) / DIG;
   localparam int NC2  = (NMW + DIG - 1) / DIG;
   localparam int MP1  = NC1 * DIG;
   localparam int MP2  = NC2 * DIG;
   localparam int X1   = HW + CW + RADW + 1;
   localparam int XS   = HW + AW + 2;
   localparam int XN   = AW + W + 3;
   localparam int XQ   = W + 3;

   localparam logic signed [W+1:0] DIST_MAX = {3'b000, {(W-1){1'b1}}};

   // ---------------- stage 1: offsets ----------------
   logic signed [W-1:0]  org [3];
   logic signed [W-1:0]  dir [3];
   logic signed [W-1:0]  ctr [3];
   logic signed [LW-1:0] l_in [3];
   logic signed [LW-1:0] l_ff [3];
   logic signed [W-1:0]  d_ff [3];
   logic [RADW-1:0]      rad1_ff;
   logic                 v1_ff;

   assign busy   = 1'b0;
   assign org[0] = req_ray_origin_x;
   assign org[1] = req_ray_origin_y;
   assign org[2] = req_ray_origin_z;
   assign dir[0] = req_ray_dir_x;
   assign dir[1] = req_ray_dir_y;
   assign dir[2] = req_ray_dir_z;
   assign ctr[0] = req_center_x;
   assign ctr[1] = req_center_y;
   assign ctr[2] = req_center_z;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         l_in[k] = LW'(org[k]) - LW'(ctr[k]);
      end
   end

   // ---------------- stage 2: products ----------------
   logic signed [PRW-1:0] pld_in [3];
   logic signed [PRW-1:0] pld_ff [3];
   logic signed [LLW-1:0] pll_in [3];
   logic signed [LLW-1:0] pll_ff [3];
   logic signed [AW-1:0]  pdd_in [3];
   logic signed [AW-1:0]  pdd_ff [3];
   logic [2*RADW-1:0]     r2_ff;
   logic [RADW-1:0]       rad2_ff;
   logic                  inv2_ff;
   logic                  v2_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pld_in[k] = l_ff[k] * d_ff[k];
         pll_in[k] = l_ff[k] * l_ff[k];
         pdd_in[k] = d_ff[k] * d_ff[k];
      end
   end

   // ---------------- stage 3: dot products ----------------
   logic signed [HW-1:0] h_in, h3_ff;
   logic [AW-1:0]        a_in, a3_ff;
   logic [CW-1:0]        c0_in, c03_ff;
   logic signed [KW-1:0] k_in, k3_ff;
   logic [RADW-1:0]      rad3_ff;
   logic                 inv3_ff;
   logic                 v3_ff;

   assign h_in  = HW'(pld_ff[0]) + HW'(pld_ff[1]) + HW'(pld_ff[2]);
   assign a_in  = AW'($unsigned(pdd_ff[0])) + AW'($unsigned(pdd_ff[1]))
                + AW'($unsigned(pdd_ff[2]));
   assign c0_in = CW'($unsigned(pll_ff[0])) + CW'($unsigned(pll_ff[1]))
                + CW'($unsigned(pll_ff[2]));
   assign k_in  = $signed(KW'(c0_in)) - $signed(KW'(r2_ff));

   // ---------------- stage 4: magnitudes ----------------
   logic [HM-1:0]        habs_in, habs_ff;
   logic [HM-1:0]        kabs_in, kabs_ff;
   logic signed [HW-1:0] h4_ff;
   logic [AW-1:0]        a4_ff;
   logic [CW-1:0]        c04_ff;
   logic [RADW-1:0]      rad4_ff;
   logic                 ksgn4_ff;
   logic                 inv4_ff;
   logic                 v4_ff;

   assign habs_in = h3_ff[HW-1] ? HM'(-h3_ff) : HM'(h3_ff);
   assign kabs_in = k3_ff[KW-1] ? HM'(-k3_ff) : HM'(k3_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         l_ff[k]   <= l_in[k];
         d_ff[k]   <= dir[k];
         pld_ff[k] <= pld_in[k];
         pll_ff[k] <= pll_in[k];
         pdd_ff[k] <= pdd_in[k];
      end
      rad1_ff  <= req_sphere_radius;
      r2_ff    <= rad1_ff * rad1_ff;
      rad2_ff  <= rad1_ff;
      inv2_ff  <= (d_ff[0] == '0) && (d_ff[1] == '0) && (d_ff[2] == '0);
      h3_ff    <= h_in;
      a3_ff    <= a_in;
      c03_ff   <= c0_in;
      k3_ff    <= k_in;
      rad3_ff  <= rad2_ff;
      inv3_ff  <= inv2_ff;
      habs_ff  <= habs_in;
      kabs_ff  <= kabs_in;
      h4_ff    <= h3_ff;
      a4_ff    <= a3_ff;
      c04_ff   <= c03_ff;
      rad4_ff  <= rad3_ff;
      ksgn4_ff <= k3_ff[KW-1];
      inv4_ff  <= inv3_ff;
   end

   // ---------------- product chains: h*h and a*|k| ----------------
   logic           m1_vld [NC1+1];
   logic [HM-1:0]  m1_mc  [NC1+1];
   logic [MP1-1:0] m1_mp  [NC1+1];
   logic [SQW-1:0] m1_acc [NC1+1];
   logic [X1-1:0]  m1_side[NC1+1];
   logic           m2_vld [NC1+1];
   logic [AW-1:0]  m2_mc  [NC1+1];
   logic [MP1-1:0] m2_mp  [NC1+1];
   logic [SQW-1:0] m2_acc [NC1+1];
   logic           m2_side[NC1+1];

   assign m1_vld[0]  = v4_ff;
   assign m1_mc[0]   = habs_ff;
   assign m1_mp[0]   = MP1'(habs_ff);
   assign m1_acc[0]  = '0;
   assign m1_side[0] = {h4_ff, c04_ff, rad4_ff, inv4_ff};
   assign m2_vld[0]  = v4_ff;
   assign m2_mc[0]   = a4_ff;
   assign m2_mp[0]   = MP1'(kabs_ff);
   assign m2_acc[0]  = '0;
   assign m2_side[0] = ksgn4_ff;

   for (genvar i = 0; i < NC1; i++) begin : g_mul1
      rsh_mul_cell #(
         .MW(HM), .DW(MP1), .PW(SQW), .XW(X1), .IDX(i), .DIG(DIG)
      ) u_hh (
         .clock(clock), .reset(reset),
         .up_vld(m1_vld[i]), .up_mcand(m1_mc[i]), .up_mplier(m1_mp[i]),
         .up_acc(m1_acc[i]), .up_side(m1_side[i]),
         .dn_vld(m1_vld[i+1]), .dn_mcand(m1_mc[i+1]), .dn_mplier(m1_mp[i+1]),
         .dn_acc(m1_acc[i+1]), .dn_side(m1_side[i+1])
      );
      rsh_mul_cell #(
         .MW(AW), .DW(MP1), .PW(SQW), .XW(1), .IDX(i), .DIG(DIG)
      ) u_ak (
         .clock(clock), .reset(reset),
         .up_vld(m2_vld[i]), .up_mcand(m2_mc[i]), .up_mplier(m2_mp[i]),
         .up_acc(m2_acc[i]), .up_side(m2_side[i]),
         .dn_vld(m2_vld[i+1]), .dn_mcand(m2_mc[i+1]), .dn_mplier(m2_mp[i+1]),
         .dn_acc(m2_acc[i+1]), .dn_side(m2_side[i+1])
      );
   end

   // ---------------- discriminant ----------------
   logic signed [HW-1:0] h5;
   logic [CW-1:0]        c05;
   logic [RADW-1:0]      rad5;
   logic                 inv5;
   logic [SQW-1:0]       hsq, ak;
   logic                 ksgn5;
   logic [SQW-1:0]       dmag_in, dmag_ff;
   logic                 dneg_in, dneg_ff;
   logic signed [HW-1:0] h6_ff;
   logic [AW-1:0]        a6_ff;
   logic [CW-1:0]        c06_ff;
   logic [RADW-1:0]      rad6_ff;
   logic                 inv6_ff;
   logic                 v6_ff;

   assign {h5, c05, rad5, inv5} = m1_side[NC1];
   assign hsq     = m1_acc[NC1];
   assign ak      = m2_acc[NC1];
   assign ksgn5   = m2_side[NC1];
   // negative k makes a*k negative, so the discriminant grows
   assign dneg_in = !ksgn5 && (ak > hsq);
   assign dmag_in = ksgn5 ? hsq + ak : hsq - ak;

   // ---------------- root search: sqrt(disc) and sqrt(L.L) ----------------
   logic           s_vld [HM+1];
   logic [SQW-1:0] s_rem [HM+1];
   logic [HM-1:0]  s_root[HM+1];
   logic [HM-1:0]  s_qa  [HM+1];
   logic           s_mul [HM+1];
   logic [XS-1:0]  s_side[HM+1];
   logic           c_vld [HM+1];
   logic [SQW-1:0] c_rem [HM+1];
   logic [HM-1:0]  c_root[HM+1];
   logic [HM-1:0]  c_qa  [HM+1];
   logic           c_mul [HM+1];
   logic [RADW-1:0] c_side[HM+1];

   assign s_vld[0]  = v6_ff;
   assign s_rem[0]  = dmag_ff;
   assign s_root[0] = '0;
   assign s_qa[0]   = '0;
   assign s_mul[0]  = 1'b1;
   assign s_side[0] = {h6_ff, a6_ff, dneg_ff, inv6_ff};
   assign c_vld[0]  = v6_ff;
   assign c_rem[0]  = SQW'(c06_ff);
   assign c_root[0] = '0;
   assign c_qa[0]   = '0;
   assign c_mul[0]  = 1'b1;
   assign c_side[0] = rad6_ff;

   for (genvar i = 0; i < HM; i++) begin : g_sqrt
      rsh_search_cell #(
         .RW(SQW), .QW(HM), .QAW(HM), .MW(1), .XW(XS), .BIT(HM - 1 - i)
      ) u_sd (
         .clock(clock), .reset(reset),
         .up_vld(s_vld[i]), .up_rem(s_rem[i]), .up_root(s_root[i]),
         .up_qa(s_qa[i]), .up_mul(s_mul[i]), .up_side(s_side[i]),
         .dn_vld(s_vld[i+1]), .dn_rem(s_rem[i+1]), .dn_root(s_root[i+1]),
         .dn_qa(s_qa[i+1]), .dn_mul(s_mul[i+1]), .dn_side(s_side[i+1])
      );
      rsh_search_cell #(
         .RW(SQW), .QW(HM), .QAW(HM), .MW(1), .XW(RADW), .BIT(HM - 1 - i)
      ) u_cd (
         .clock(clock), .reset(reset),
         .up_vld(c_vld[i]), .up_rem(c_rem[i]), .up_root(c_root[i]),
         .up_qa(c_qa[i]), .up_mul(c_mul[i]), .up_side(c_side[i]),
         .dn_vld(c_vld[i+1]), .dn_rem(c_rem[i+1]), .dn_root(c_root[i+1]),
         .dn_qa(c_qa[i+1]), .dn_mul(c_mul[i+1]), .dn_side(c_side[i+1])
      );
   end

   // ---------------- root choice and miss distance ----------------
   logic signed [HW-1:0] h7;
   logic [AW-1:0]        a7;
   logic                 dneg7, inv7;
   logic [RADW-1:0]      rad7;
   logic signed [NW-1:0] mh, sv, n1, n2, nsel;
   logic                 nneg;
   logic signed [W+1:0]  cdiff;
   logic [W-1:0]         miss_in, miss8_ff;
   rsh_flags_type        flags_in, flags8_ff;
   logic [NMW-1:0]       nmag_ff;
   logic [AW-1:0]        a8_ff;
   logic                 v8_ff;

   assign {h7, a7, dneg7, inv7} = s_side[HM];
   assign rad7  = c_side[HM];
   assign mh    = -NW'(h7);
   assign sv    = $signed({2'b00, s_root[HM]});
   assign n1    = mh - sv;
   assign n2    = mh + sv;
   // near root when strictly ahead, else the far one
   assign nsel  = (!n1[NW-1] && (n1 != '0)) ? n1 : n2;
   assign nneg  = nsel[NW-1];
   assign cdiff = $signed({1'b0, c_root[HM][W:0]}) - $signed({3'b000, rad7});
   assign miss_in = (cdiff > DIST_MAX) ? DIST_MAX[W-1:0] : cdiff[W-1:0];

   always_comb begin
      flags_in.hit       = !dneg7;
      flags_in.front_hit = !dneg7 && !nneg && !inv7;
      flags_in.invalid   = inv7;
   end

   // ---------------- product chain: N*N ----------------
   logic           n_vld [NC2+1];
   logic [NMW-1:0] n_mc  [NC2+1];
   logic [MP2-1:0] n_mp  [NC2+1];
   logic [NSQW-1:0] n_acc[NC2+1];
   logic [XN-1:0]  n_side[NC2+1];

   assign n_vld[0]  = v8_ff;
   assign n_mc[0]   = nmag_ff;
   assign n_mp[0]   = MP2'(nmag_ff);
   assign n_acc[0]  = '0;
   assign n_side[0] = {a8_ff, miss8_ff, flags8_ff};

   for (genvar i = 0; i < NC2; i++) begin : g_mul2
      rsh_mul_cell #(
         .MW(NMW), .DW(MP2), .PW(NSQW), .XW(XN), .IDX(i), .DIG(DIG)
      ) u_nn (
         .clock(clock), .reset(reset),
         .up_vld(n_vld[i]), .up_mcand(n_mc[i]), .up_mplier(n_mp[i]),
         .up_acc(n_acc[i]), .up_side(n_side[i]),
         .dn_vld(n_vld[i+1]), .dn_mcand(n_mc[i+1]), .dn_mplier(n_mp[i+1]),
         .dn_acc(n_acc[i+1]), .dn_side(n_side[i+1])
      );
   end

   // ---------------- quotient search: largest q with q*q*a <= N*N ----------------
   logic [AW-1:0]   a9;
   logic [XQ-1:0]   side9;
   logic            q_vld [QW+1];
   logic [NSQW-1:0] q_rem [QW+1];
   logic [QW-1:0]   q_root[QW+1];
   logic [QAW-1:0]  q_qa  [QW+1];
   logic [AW-1:0]   q_mul [QW+1];
   logic [XQ-1:0]   q_side[QW+1];

   assign {a9, side9} = n_side[NC2];
   assign q_vld[0]  = n_vld[NC2];
   assign q_rem[0]  = n_acc[NC2];
   assign q_root[0] = '0;
   assign q_qa[0]   = '0;
   assign q_mul[0]  = a9;
   assign q_side[0] = side9;

   for (genvar i = 0; i < QW; i++) begin : g_quot
      rsh_search_cell #(
         .RW(NSQW), .QW(QW), .QAW(QAW), .MW(AW), .XW(XQ), .BIT(QW - 1 - i)
      ) u_q (
         .clock(clock), .reset(reset),
         .up_vld(q_vld[i]), .up_rem(q_rem[i]), .up_root(q_root[i]),
         .up_qa(q_qa[i]), .up_mul(q_mul[i]), .up_side(q_side[i]),
         .dn_vld(q_vld[i+1]), .dn_rem(q_rem[i+1]), .dn_root(q_root[i+1]),
         .dn_qa(q_qa[i+1]), .dn_mul(q_mul[i+1]), .dn_side(q_side[i+1])
      );
   end

   // ---------------- result register ----------------
   logic [W-1:0]  miss10;
   rsh_flags_type flags10;
   logic          strobe_ff;
   logic          hit_ff, front_ff, inv_ff;
   logic [W-1:0]  dist_in, dist_ff;

   assign {miss10, flags10} = q_side[QW];
   assign dist_in = flags10.invalid   ? '0 :
                    flags10.front_hit ? {1'b0, q_root[QW]} : miss10;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff     <= 1'b0;
         v8_ff     <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         v6_ff     <= m1_vld[NC1];
         v8_ff     <= s_vld[HM];
         strobe_ff <= q_vld[QW];
      end
   end

   always_ff @(posedge clock) begin
      dmag_ff   <= dmag_in;
      dneg_ff   <= dneg_in;
      h6_ff     <= h5;
      a6_ff     <= m2_mc[NC1];
      c06_ff    <= c05;
      rad6_ff   <= rad5;
      inv6_ff   <= inv5;
      nmag_ff   <= nsel[NMW-1:0];
      a8_ff     <= a7;
      miss8_ff  <= miss_in;
      flags8_ff <= flags_in;
      hit_ff    <= flags10.hit;
      front_ff  <= flags10.front_hit;
      inv_ff    <= flags10.invalid;
      dist_ff   <= dist_in;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_hit       = hit_ff;
   assign rsp_front_hit = front_ff;
   assign rsp_invalid   = inv_ff;
   assign rsp_distance  = dist_ff;

`ifndef SYNTHESIS
   a_mul_lanes_step: assert property (@(posedge clock) disable iff (reset)
      m1_vld[NC1] == m2_vld[NC1])
      else $error("product lanes out of step");

   a_sqrt_lanes_step: assert property (@(posedge clock) disable iff (reset)
      s_vld[HM] == c_vld[HM])
      else $error("root search lanes out of step");

   a_invalid_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_invalid |-> rsp_hit && !rsp_front_hit && (rsp_distance == '0))
      else $error("zero direction result malformed");

   a_front_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_front_hit |-> rsp_hit && !rsp_distance[W-1])
      else $error("front hit without hit or with negative distance");
`endif

endmodule

`default_nettype wire

FILE: test/ray_sphere_hit_distance_tb.sv
// ----------------------------------------------------------------------------
// ray_sphere_hit_distance_tb
// Self-checking bench for the ray-sphere hit distance pipeline. Rays and
// spheres go in one transaction per cycle with random gaps. Each result is
// checked against a wide-integer prediction of the discriminant, the root
// choice and the distance, including saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_sphere_hit_distance_tb;
   import rsh_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int W = RSH_COORD_WIDTH;
   localparam int ONE = 65536;
   localparam int SETTLE = 140;
   localparam int LIMIT = 400000;

   typedef struct {
      logic signed [W-1:0] ox, oy, oz, dx, dy, dz, cx, cy, cz;
      logic        [W-2:0] rad;
   } ray_pair_type;

   typedef struct {
      logic                hit, front, inv;
      logic signed [W-1:0] distance;
   } hit_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [W-1:0] req_ray_origin_x = '0, req_ray_origin_y = '0, req_ray_origin_z = '0;
   logic signed [W-1:0] req_ray_dir_x = '0, req_ray_dir_y = '0, req_ray_dir_z = '0;
   logic signed [W-1:0] req_center_x = '0, req_center_y = '0, req_center_z = '0;
   logic        [W-2:0] req_sphere_radius = '0;
   logic rsp_strobe, rsp_hit, rsp_front_hit, rsp_invalid;
   logic signed [W-1:0] rsp_distance;

   ray_pair_type   pending_rays[$];
   hit_report_type expected_reports[$];
   ray_pair_type   cur;
   int idle_pct = 0;
   int errors = 0;
   int cycles = 0;
   int n_rays = 0, n_reports = 0, n_hit = 0, n_front = 0, n_inv = 0, n_behind = 0;

   ray_sphere_hit_distance uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_ray_origin_x(req_ray_origin_x), .req_ray_origin_y(req_ray_origin_y),
      .req_ray_origin_z(req_ray_origin_z), .req_ray_dir_x(req_ray_dir_x),
      .req_ray_dir_y(req_ray_dir_y), .req_ray_dir_z(req_ray_dir_z),
      .req_center_x(req_center_x), .req_center_y(req_center_y),
      .req_center_z(req_center_z), .req_sphere_radius(req_sphere_radius),
      .rsp_strobe(rsp_strobe), .rsp_hit(rsp_hit), .rsp_front_hit(rsp_front_hit),
      .rsp_invalid(rsp_invalid), .rsp_distance(rsp_distance)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [255:0] floor_sqrt(input logic [255:0] x);
      logic [255:0] r, c;
      r = '0;
      for (int b = 127; b >= 0; b--) begin
         c = r | (256'd1 << b);
         if (c * c <= x) r = c;
      end
      return r;
   endfunction

   function automatic hit_report_type predict_hit(input ray_pair_type p);
      logic signed [255:0] lv[3], dv[3];
      logic signed [255:0] h, a, c0, rv, k, disc, s, n1, n2, n, cd;
      logic [255:0] nsq, q, cand;
      hit_report_type e;
      lv[0] = p.ox - p.cx; lv[1] = p.oy - p.cy; lv[2] = p.oz - p.cz;
      dv[0] = p.dx; dv[1] = p.dy; dv[2] = p.dz;
      rv = p.rad;
      h = 0; a = 0; c0 = 0;
      for (int i = 0; i < 3; i++) begin
         h = h + lv[i] * dv[i];
         a = a + dv[i] * dv[i];
         c0 = c0 + lv[i] * lv[i];
      end
      e = '{hit: 1'b1, front: 1'b0, inv: 1'b0, distance: '0};
      if (a == 0) begin
         e.inv = 1'b1;
         return e;
      end
      k = c0 - rv * rv;
      disc = h * h - a * k;
      // center distance minus radius, clamped to the output range
      cd = $signed(floor_sqrt(c0)) - rv;
      if (cd > 64'sd2147483647) cd = 64'sd2147483647;
      if (cd < -64'sd2147483648) cd = -64'sd2147483648;
      e.distance = cd[W-1:0];
      if (disc < 0) begin
         e.hit = 1'b0;
         return e;
      end
      s = $signed(floor_sqrt(disc));
      n1 = -h - s;
      n2 = -h + s;
      n = (n1 > 0) ? n1 : n2;
      if (n < 0) return e;
      nsq = n * n;
      q = '0;
      for (int b = W - 2; b >= 0; b--) begin
         cand = q | (256'd1 << b);
         if (cand * cand * a <= nsq) q = cand;
      end
      e.front = 1'b1;
      e.distance = q[W-1:0];
      return e;
   endfunction

   function automatic ray_pair_type mk(input int ox, oy, oz, dx, dy, dz, cx, cy, cz,
                                       input logic [W-2:0] r);
      ray_pair_type p;
      p = '{ox: ox, oy: oy, oz: oz, dx: dx, dy: dy, dz: dz, cx: cx, cy: cy, cz: cz, rad: r};
      return p;
   endfunction

   task automatic queue_ray(input ray_pair_type p);
      pending_rays.insert(pending_rays.size(), p);
   endtask

   function automatic int spread(input int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   // well-formed aim at the sphere with some jitter, or plain noise
   function automatic ray_pair_type random_pair();
      ray_pair_type p;
      int cx, cy, cz, ox, oy, oz, sh, sel;
      sel = $urandom_range(0, 99);
      if (sel < 25) begin
         p = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, (W-1)'($urandom));
         return p;
      end
      cx = spread(1 << 22); cy = spread(1 << 22); cz = spread(1 << 22);
      ox = cx + spread(1 << 23); oy = cy + spread(1 << 23); oz = cz + spread(1 << 23);
      sh = $urandom_range(0, 8);
      p = mk(ox, oy, oz,
             ((cx - ox) >>> sh) + spread(1 << ($urandom_range(4, 20))),
             ((cy - oy) >>> sh) + spread(1 << ($urandom_range(4, 20))),
             ((cz - oz) >>> sh) + spread(1 << ($urandom_range(4, 20))),
             cx, cy, cz, (W-1)'($urandom_range(0, 1 << 22)));
      // turn some rays around so the sphere is behind, and give others a tiny direction
      if (sel < 35) begin
         p.dx = -p.dx; p.dy = -p.dy; p.dz = -p.dz;
      end else if (sel < 40) begin
         p.dx = spread(2); p.dy = spread(2); p.dz = spread(2);
      end
      return p;
   endfunction

   // driver: one transaction per accepted edge, random gaps
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_reports.insert(expected_reports.size(), predict_hit(cur));
            n_rays++;
         end
         if (start && busy) begin
            // hold the current transaction
         end else if (pending_rays.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
            cur = pending_rays.pop_front();
            start <= 1'b1;
            req_ray_origin_x <= cur.ox; req_ray_origin_y <= cur.oy; req_ray_origin_z <= cur.oz;
            req_ray_dir_x <= cur.dx; req_ray_dir_y <= cur.dy; req_ray_dir_z <= cur.dz;
            req_center_x <= cur.cx; req_center_y <= cur.cy; req_center_z <= cur.cz;
            req_sphere_radius <= cur.rad;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      hit_report_type e;
      if (!reset && rsp_strobe) begin
         n_reports++;
         if (expected_reports.size() == 0) begin
            $display("%0t: unexpected result hit=%0b front=%0b inv=%0b distance=%0d",
                     $time, rsp_hit, rsp_front_hit, rsp_invalid, rsp_distance);
            errors++;
         end else begin
            e = expected_reports.pop_front();
            n_hit += e.hit; n_front += e.front; n_inv += e.inv;
            n_behind += (e.hit && !e.front && !e.inv);
            if (rsp_hit !== e.hit) begin
               $display("%0t: hit expected %0b actual %0b", $time, e.hit, rsp_hit);
               errors++;
            end
            if (rsp_front_hit !== e.front) begin
               $display("%0t: front_hit expected %0b actual %0b", $time, e.front, rsp_front_hit);
               errors++;
            end
            if (rsp_invalid !== e.inv) begin
               $display("%0t: invalid expected %0b actual %0b", $time, e.inv, rsp_invalid);
               errors++;
            end
            if (rsp_distance !== e.distance) begin
               $display("%0t: distance expected %0d actual %0d", $time, e.distance,
                        rsp_distance);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: zero direction, near root, inside, behind, miss, tangent, then scaled directions and extremes
      queue_ray(mk(5 * ONE, -3 * ONE, ONE, 0, 0, 0, 0, 0, 0, ONE));
      queue_ray(mk(0, 0, -10 * ONE, 0, 0, ONE, 0, 0, 0, ONE));
      queue_ray(mk(0, 0, 0, ONE, 0, 0, 0, 0, 0, 2 * ONE));
      queue_ray(mk(0, 0, 10 * ONE, 0, 0, ONE, 0, 0, 0, ONE));
      queue_ray(mk(0, 5 * ONE, -10 * ONE, 0, 0, ONE, 0, 0, 0, ONE));
      queue_ray(mk(0, ONE, -10 * ONE, 0, 0, ONE, 0, 0, 0, ONE));
      queue_ray(mk(0, 0, -10 * ONE, 0, 0, 7 * ONE, 0, 0, 0, ONE));
      queue_ray(mk(3 * ONE, 4 * ONE, 0, -3, -4, 0, 0, 0, 0, ONE / 2));
      queue_ray(mk(0, 0, 0, 1, 0, 0, 0, 0, 0, '1));
      queue_ray(mk(32'h8000_0000, 0, 0, 32'h7fff_ffff, 0, 0,
                   32'h7fff_ffff, 0, 0, 1));
      queue_ray(mk(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0));
      queue_ray(mk(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                   32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                   32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, '1));
      queue_ray(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '1));
      queue_ray(mk(32'h7fff_ffff, 0, 0, 1, 1, 1,
                   32'h8000_0000, 32'h8000_0000, 0, 0));
      queue_ray(mk(-1, -1, -1, -1, -1, -1, 0, 0, 0, 0));

      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 16 : (phase == 1) ? 45 : 0;
         for (int i = 0; i < 215; i++) queue_ray(random_pair());
         // hold off until the pipeline has drained
         while (pending_rays.size() > 0 || start || expected_reports.size() > 0)
            @(posedge clock);
      end
      repeat (SETTLE) @(posedge clock);

      $display("sent %0d rays, checked %0d results: %0d hits, %0d ahead, %0d behind, %0d invalid",
               n_rays, n_reports, n_hit, n_front, n_behind, n_inv);
      if (errors == 0 && expected_reports.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches, %0d results missing", errors, expected_reports.size());
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire
